>>> rtl/core/assert_macros.svh
// assertion macros for the rtl of the complex arithmetic unit
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/cau_pkg.sv
// shared types and codes of the complex arithmetic unit
// no dependencies; used by the interfaces and the top level
package cau_pkg;

   // operation select codes
   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_EQ  = 3'd4,
      MODE_NE  = 3'd5
   } mode_type;

   localparam int unsigned MODE_WIDTH = 3;

endpackage

>>> rtl/core/cau_ifs.sv
// valid/ready channel interfaces for operands and results
// depends on cau_pkg for the width of the operation select
interface cau_req_if #(parameter int DATA_WIDTH = 16);
   logic                                 valid;
   logic                                 ready;
   logic [cau_pkg::MODE_WIDTH-1:0]       mode;
   logic signed [DATA_WIDTH-1:0]         a_real;
   logic signed [DATA_WIDTH-1:0]         a_imag;
   logic signed [DATA_WIDTH-1:0]         b_real;
   logic signed [DATA_WIDTH-1:0]         b_imag;

   modport source (output valid, mode, a_real, a_imag, b_real, b_imag, input ready);
   modport sink   (input valid, mode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if #(parameter int DATA_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  result_real;
   logic signed [DATA_WIDTH-1:0]  result_imag;
   logic                          compare_true;
   logic                          saturated;
   logic                          divide_by_zero;

   modport source (output valid, result_real, result_imag, compare_true, saturated,
                   divide_by_zero, input ready);
   modport sink   (input valid, result_real, result_imag, compare_true, saturated,
                   divide_by_zero, output ready);
endinterface

>>> rtl/core/complex_arithmetic_unit.sv
// complex arithmetic unit: add, sub, mul, div and compare on fixed-point complex pairs
// depends on cau_pkg, the channel interfaces in cau_ifs.sv and assert_macros.svh
//
// usage
//   req carries one operand pair and an operation select per transaction; rsp
//   returns one result transaction for every request, in order.
//   the block is a single pipeline: an input register, a multiplier stage, a
//   combine stage, a prepare stage, DATA_WIDTH+1 restoring divider steps (one
//   quotient bit each, real and imaginary in parallel) and an output register.
//   one transaction can be accepted every cycle while the output is not stalled,
//   the pipeline depth being set by the one-bit-per-stage divider.
//   out of range results saturate and raise saturated; a zero divisor gives a
//   zero result with divide_by_zero set.
//   reset clears every valid bit of the pipeline; no result is pending after.
//   when the receiver holds rsp.ready low with a result waiting, the whole
//   pipeline freezes and req.ready drops; nothing is lost or repeated and
//   empty stages never hold it back.
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req,
   cau_rsp_if.source rsp
);

`include "assert_macros.svh"

   localparam int W    = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int DW   = 2 * W;          // product / denominator width
   localparam int XW   = DW + 1;         // combined signed sum width
   localparam int MW   = XW;             // magnitude width
   localparam int CW   = MW + 1;         // magnitude after rounding
   localparam int NW   = MW + F;         // scaled dividend width
   localparam int QW   = W + 1;          // quotient bits kept
   localparam int RW   = DW + 1;         // partial remainder width
   localparam int BW   = NW + DW + QW;   // overflow compare width
   localparam int NSTG = QW + 5;         // valid bits along the pipeline

   localparam logic [CW-1:0] HALF    = (F > 0) ? (CW'(1) << ((F > 0) ? F - 1 : 0)) : '0;
   localparam logic [CW-1:0] MAG_MIN = CW'(1) << (W - 1);
   localparam logic [CW-1:0] MAG_MAX = MAG_MIN - CW'(1);

   typedef struct packed {
      logic [W-1:0] val;
      logic         sat;
   } clamp_type;

   typedef struct packed {
      logic [W-1:0]  res_r;
      logic [W-1:0]  res_i;
      logic          cmp;
      logic          sat;
      logic          dz;
      logic          is_div;
      logic          neg_r;
      logic          neg_i;
      logic          big_r;
      logic          big_i;
      logic [DW-1:0] den;
      logic [NW-1:0] n_r;
      logic [NW-1:0] n_i;
      logic [RW-1:0] rem_r;
      logic [RW-1:0] rem_i;
      logic [QW-1:0] q_r;
      logic [QW-1:0] q_i;
   } stage_type;

   typedef struct packed {
      logic [W-1:0] res_r;
      logic [W-1:0] res_i;
      logic         cmp;
      logic         sat;
      logic         dz;
   } out_type;

   // clamp a sign/magnitude value into the signed output range
   function automatic clamp_type clamp_part(input logic neg, input logic [CW-1:0] mag);
      clamp_type     r;
      logic [CW-1:0] m;
      m = mag;
      r.sat = 1'b0;
      if (neg) begin
         if (mag > MAG_MIN) begin
            m = MAG_MIN;
            r.sat = 1'b1;
         end
         r.val = W'(CW'(0) - m);
      end else begin
         if (mag > MAG_MAX) begin
            m = MAG_MAX;
            r.sat = 1'b1;
         end
         r.val = W'(m);
      end
      return r;
   endfunction

   // pipeline advance: frozen only when a finished result is not taken
   logic            en;
   logic [NSTG-1:0] vld_ff, vld_in;

   assign en        = !vld_ff[NSTG-1] || rsp.ready;
   assign req.ready = en;
   assign vld_in    = {vld_ff[NSTG-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // input register
   logic [2:0]          mode0_ff;
   logic signed [W-1:0] ar0_ff, ai0_ff, br0_ff, bi0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mode0_ff <= req.mode;
         ar0_ff   <= req.a_real;
         ai0_ff   <= req.a_imag;
         br0_ff   <= req.b_real;
         bi0_ff   <= req.b_imag;
      end
   end

   // products, sums and equality
   logic [2:0]           mode1_ff;
   logic signed [DW-1:0] p_rr1_ff, p_ii1_ff, p_ri1_ff, p_ir1_ff, p_dr1_ff, p_di1_ff;
   logic signed [W:0]    sum_r1_ff, sum_i1_ff, sum_r1_in, sum_i1_in;
   logic                 eq1_ff;

   always_comb begin
      if (mode0_ff == cau_pkg::MODE_SUB) begin
         sum_r1_in = (W+1)'(ar0_ff) - (W+1)'(br0_ff);
         sum_i1_in = (W+1)'(ai0_ff) - (W+1)'(bi0_ff);
      end else begin
         sum_r1_in = (W+1)'(ar0_ff) + (W+1)'(br0_ff);
         sum_i1_in = (W+1)'(ai0_ff) + (W+1)'(bi0_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff  <= mode0_ff;
         p_rr1_ff  <= DW'(ar0_ff) * DW'(br0_ff);
         p_ii1_ff  <= DW'(ai0_ff) * DW'(bi0_ff);
         p_ri1_ff  <= DW'(ar0_ff) * DW'(bi0_ff);
         p_ir1_ff  <= DW'(ai0_ff) * DW'(br0_ff);
         p_dr1_ff  <= DW'(br0_ff) * DW'(br0_ff);
         p_di1_ff  <= DW'(bi0_ff) * DW'(bi0_ff);
         sum_r1_ff <= sum_r1_in;
         sum_i1_ff <= sum_i1_in;
         eq1_ff    <= (ar0_ff == br0_ff) && (ai0_ff == bi0_ff);
      end
   end

   // combine products per operation
   logic [2:0]           mode2_ff;
   logic signed [XW-1:0] x_r2_ff, x_i2_ff, x_r2_in, x_i2_in;
   logic [DW-1:0]        den2_ff;
   logic                 eq2_ff;

   always_comb begin
      case (mode1_ff)
         cau_pkg::MODE_MUL: begin
            x_r2_in = XW'(p_rr1_ff) - XW'(p_ii1_ff);
            x_i2_in = XW'(p_ri1_ff) + XW'(p_ir1_ff);
         end
         cau_pkg::MODE_DIV: begin
            x_r2_in = XW'(p_rr1_ff) + XW'(p_ii1_ff);
            x_i2_in = XW'(p_ir1_ff) - XW'(p_ri1_ff);
         end
         default: begin
            x_r2_in = XW'(sum_r1_ff);
            x_i2_in = XW'(sum_i1_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode2_ff <= mode1_ff;
         x_r2_ff  <= x_r2_in;
         x_i2_ff  <= x_i2_in;
         den2_ff  <= DW'($unsigned(p_dr1_ff)) + DW'($unsigned(p_di1_ff));
         eq2_ff   <= eq1_ff;
      end
   end

   // prepare: finish non-divide results, set up the divider
   stage_type prep_in;
   stage_type p_ff [0:QW];
   stage_type p_in [0:QW];

   always_comb begin
      logic          neg_r, neg_i;
      logic [MW-1:0] mag_r, mag_i;
      logic [CW-1:0] rnd_r, rnd_i;
      clamp_type     c_r, c_i;
      neg_r = x_r2_ff[XW-1];
      neg_i = x_i2_ff[XW-1];
      mag_r = neg_r ? MW'(-x_r2_ff) : MW'(x_r2_ff);
      mag_i = neg_i ? MW'(-x_i2_ff) : MW'(x_i2_ff);
      rnd_r = (CW'(mag_r) + HALF) >> F;
      rnd_i = (CW'(mag_i) + HALF) >> F;
      if (mode2_ff == cau_pkg::MODE_MUL) begin
         c_r = clamp_part(neg_r, rnd_r);
         c_i = clamp_part(neg_i, rnd_i);
      end else begin
         c_r = clamp_part(neg_r, CW'(mag_r));
         c_i = clamp_part(neg_i, CW'(mag_i));
      end

      prep_in        = '0;
      prep_in.neg_r  = neg_r;
      prep_in.neg_i  = neg_i;
      prep_in.den    = den2_ff;
      prep_in.n_r    = NW'(mag_r) << F;
      prep_in.n_i    = NW'(mag_i) << F;
      prep_in.big_r  = BW'(prep_in.n_r) >= (BW'(den2_ff) << QW);
      prep_in.big_i  = BW'(prep_in.n_i) >= (BW'(den2_ff) << QW);
      prep_in.rem_r  = RW'(prep_in.n_r >> QW);
      prep_in.rem_i  = RW'(prep_in.n_i >> QW);
      case (mode2_ff)
         cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_MUL: begin
            prep_in.res_r = c_r.val;
            prep_in.res_i = c_i.val;
            prep_in.sat   = c_r.sat | c_i.sat;
         end
         cau_pkg::MODE_DIV: begin
            prep_in.is_div = (den2_ff != '0);
            prep_in.dz     = (den2_ff == '0);
         end
         cau_pkg::MODE_EQ: begin
            prep_in.cmp = eq2_ff;
         end
         cau_pkg::MODE_NE: begin
            prep_in.cmp = !eq2_ff;
         end
         default: begin
         end
      endcase
   end

   // restoring divider steps, one quotient bit per stage
   always_comb begin
      logic [RW-1:0] t_r, t_i;
      logic          ge_r, ge_i;
      p_in[0] = prep_in;
      for (int k = 0; k < QW; k++) begin
         t_r  = {p_ff[k].rem_r[RW-2:0], p_ff[k].n_r[QW-1-k]};
         t_i  = {p_ff[k].rem_i[RW-2:0], p_ff[k].n_i[QW-1-k]};
         ge_r = t_r >= RW'(p_ff[k].den);
         ge_i = t_i >= RW'(p_ff[k].den);
         p_in[k+1]       = p_ff[k];
         p_in[k+1].rem_r = ge_r ? t_r - RW'(p_ff[k].den) : t_r;
         p_in[k+1].rem_i = ge_i ? t_i - RW'(p_ff[k].den) : t_i;
         p_in[k+1].q_r   = {p_ff[k].q_r[QW-2:0], ge_r};
         p_in[k+1].q_i   = {p_ff[k].q_i[QW-2:0], ge_i};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QW; k++) begin
            p_ff[k] <= p_in[k];
         end
      end
   end

   // round quotient to nearest, clamp, output register
   out_type out_ff, out_in;

   always_comb begin
      logic          rb_r, rb_i;
      logic [CW-1:0] qr_r, qr_i;
      clamp_type     d_r, d_i;
      rb_r = {p_ff[QW].rem_r, 1'b0} >= {1'b0, RW'(p_ff[QW].den)};
      rb_i = {p_ff[QW].rem_i, 1'b0} >= {1'b0, RW'(p_ff[QW].den)};
      qr_r = p_ff[QW].big_r ? '1 : CW'(p_ff[QW].q_r) + CW'(rb_r);
      qr_i = p_ff[QW].big_i ? '1 : CW'(p_ff[QW].q_i) + CW'(rb_i);
      d_r  = clamp_part(p_ff[QW].neg_r, qr_r);
      d_i  = clamp_part(p_ff[QW].neg_i, qr_i);
      out_in.cmp = p_ff[QW].cmp;
      out_in.dz  = p_ff[QW].dz;
      if (p_ff[QW].is_div) begin
         out_in.res_r = d_r.val;
         out_in.res_i = d_i.val;
         out_in.sat   = d_r.sat | d_i.sat;
      end else begin
         out_in.res_r = p_ff[QW].res_r;
         out_in.res_i = p_ff[QW].res_i;
         out_in.sat   = p_ff[QW].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid          = vld_ff[NSTG-1];
   assign rsp.result_real    = out_ff.res_r;
   assign rsp.result_imag    = out_ff.res_i;
   assign rsp.compare_true   = out_ff.cmp;
   assign rsp.saturated      = out_ff.sat;
   assign rsp.divide_by_zero = out_ff.dz;

   // checks
   `ASSERT_IMPL(a_dz_zero, clock, reset, rsp.valid && rsp.divide_by_zero,
                rsp.result_real == '0 && rsp.result_imag == '0 && !rsp.saturated)
   `ASSERT_IMPL(a_cmp_excl, clock, reset, rsp.valid && rsp.compare_true,
                !rsp.saturated && !rsp.divide_by_zero && rsp.result_real == '0)
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp.valid)

endmodule

>>> tb/tb.sv
// self-checking testbench of the complex arithmetic unit: directed table, then random traffic
// depends on cau_pkg, the channel interfaces in cau_ifs.sv and complex_arithmetic_unit
module tb;

   localparam int DW = 16;
   localparam int FB = 8;
   localparam int LATENCY = DW + 6;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 680;
   localparam int N_DIRECTED = 20;

   localparam logic signed [DW-1:0] MAXV = 16'sh7fff;
   localparam logic signed [DW-1:0] MINV = -16'sh8000;
   localparam logic signed [DW-1:0] ONE = 16'sh0100;
   localparam logic [2:0] MODE_UNUSED6 = 3'd6;
   localparam logic [2:0] MODE_UNUSED7 = 3'd7;

   typedef struct packed {
      logic [2:0]              mode;
      logic signed [DW-1:0]    ar;
      logic signed [DW-1:0]    ai;
      logic signed [DW-1:0]    br;
      logic signed [DW-1:0]    bi;
   } operands_type;

   typedef struct packed {
      logic signed [DW-1:0]    rr;
      logic signed [DW-1:0]    ri;
      logic                    cmp;
      logic                    sat;
      logic                    dz;
   } result_type;

   typedef struct {
      operands_type op;
      bit           typed;
      result_type   res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cau_req_if #(.DATA_WIDTH(DW)) req_ch ();
   cau_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #6 clock = ~clock;

   result_type   expected_q[$];
   int           errors = 0;
   int           n_sent = 0;
   int           n_results = 0;
   int           n_sat = 0;
   int           n_dz = 0;
   int           idle_cycles = 0;
   bit           sending_done = 1'b0;
   bit           long_holdoff = 1'b0;
   stim_row_type directed[N_DIRECTED];

   // clamp a signed wide value into the output range
   function automatic logic signed [DW-1:0] clamp_part(input logic signed [71:0] v,
                                                       inout logic sat);
      if (v > 72'sd32767) begin
         sat = 1'b1;
         return MAXV;
      end
      if (v < -72'sd32768) begin
         sat = 1'b1;
         return MINV;
      end
      return v[DW-1:0];
   endfunction

   // round to nearest, ties away from zero, of num * 2^FB / den
   function automatic logic signed [71:0] scaled_quot(input logic signed [71:0] num,
                                                      input logic signed [71:0] den);
      logic [71:0] mag;
      logic [71:0] q;
      mag = (num < 0) ? -num : num;
      q = ((mag << FB) * 2 + den) / (2 * den);
      return (num < 0) ? -$signed(q) : $signed(q);
   endfunction

   // shift a product down by FB, rounding half away from zero
   function automatic logic signed [71:0] round_prod(input logic signed [71:0] v);
      logic [71:0] mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (72'd1 << (FB - 1))) >> FB;
      return (v < 0) ? -$signed(mag) : $signed(mag);
   endfunction

   // predicted result of one operand pair
   function automatic result_type complex_result(input operands_type op);
      result_type r;
      logic signed [71:0] ar, ai, br, bi, xr, xi, den;
      logic sat;
      r = '0;
      sat = 1'b0;
      ar = 72'(op.ar); ai = 72'(op.ai); br = 72'(op.br); bi = 72'(op.bi);
      case (op.mode)
         cau_pkg::MODE_ADD: begin
            r.rr = clamp_part(ar + br, sat);
            r.ri = clamp_part(ai + bi, sat);
         end
         cau_pkg::MODE_SUB: begin
            r.rr = clamp_part(ar - br, sat);
            r.ri = clamp_part(ai - bi, sat);
         end
         cau_pkg::MODE_MUL: begin
            r.rr = clamp_part(round_prod(ar * br - ai * bi), sat);
            r.ri = clamp_part(round_prod(ar * bi + ai * br), sat);
         end
         cau_pkg::MODE_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               xr = ar * br + ai * bi;
               xi = ai * br - ar * bi;
               r.rr = clamp_part(scaled_quot(xr, den), sat);
               r.ri = clamp_part(scaled_quot(xi, den), sat);
            end
         end
         cau_pkg::MODE_EQ: r.cmp = (op.ar == op.br) && (op.ai == op.bi);
         cau_pkg::MODE_NE: r.cmp = (op.ar != op.br) || (op.ai != op.bi);
         default: ;
      endcase
      r.sat = sat;
      return r;
   endfunction

   function automatic operands_type mk(input logic [2:0] m, input logic signed [DW-1:0] ar,
                                       input logic signed [DW-1:0] ai,
                                       input logic signed [DW-1:0] br,
                                       input logic signed [DW-1:0] bi);
      operands_type o;
      o.mode = m; o.ar = ar; o.ai = ai; o.br = br; o.bi = bi;
      return o;
   endfunction

   function automatic result_type rs(input logic signed [DW-1:0] rr,
                                     input logic signed [DW-1:0] ri,
                                     input logic cmp, input logic sat, input logic dz);
      result_type r;
      r.rr = rr; r.ri = ri; r.cmp = cmp; r.sat = sat; r.dz = dz;
      return r;
   endfunction

   // directed table: typed results where obvious, predictor elsewhere
   initial begin
      directed[0]  = '{mk(cau_pkg::MODE_ADD, MAXV, MINV, MAXV, MINV), 1,
                       rs(MAXV, MINV, 0, 1, 0)};
      directed[1]  = '{mk(cau_pkg::MODE_ADD, ONE, -ONE, ONE, ONE), 1,
                       rs(16'sh0200, 0, 0, 0, 0)};
      directed[2]  = '{mk(cau_pkg::MODE_SUB, MINV, MAXV, MAXV, MINV), 1,
                       rs(MINV, MAXV, 0, 1, 0)};
      directed[3]  = '{mk(cau_pkg::MODE_SUB, 0, 0, MINV, 0), 1, rs(MAXV, 0, 0, 1, 0)};
      directed[4]  = '{mk(cau_pkg::MODE_MUL, ONE, 0, ONE, 0), 1, rs(ONE, 0, 0, 0, 0)};
      directed[5]  = '{mk(cau_pkg::MODE_MUL, MINV, MINV, MINV, MINV), 0, '0};
      directed[6]  = '{mk(cau_pkg::MODE_MUL, MAXV, MAXV, MAXV, MINV), 0, '0};
      directed[7]  = '{mk(cau_pkg::MODE_MUL, 16'sd1, 0, 16'sh0080, 0), 0, '0};
      directed[8]  = '{mk(cau_pkg::MODE_MUL, -16'sd1, 0, 16'sh0080, 0), 0, '0};
      directed[9]  = '{mk(cau_pkg::MODE_DIV, MAXV, MINV, 0, 0), 1, rs(0, 0, 0, 0, 1)};
      directed[10] = '{mk(cau_pkg::MODE_DIV, ONE, ONE, ONE, 0), 1, rs(ONE, ONE, 0, 0, 0)};
      directed[11] = '{mk(cau_pkg::MODE_DIV, MAXV, MAXV, 16'sd1, 0), 0, '0};
      directed[12] = '{mk(cau_pkg::MODE_DIV, MINV, MAXV, MINV, MINV), 0, '0};
      directed[13] = '{mk(cau_pkg::MODE_DIV, 16'sd1, 0, 16'sd3, 16'sd1), 0, '0};
      directed[14] = '{mk(cau_pkg::MODE_EQ, MINV, MAXV, MINV, MAXV), 1, rs(0, 0, 1, 0, 0)};
      directed[15] = '{mk(cau_pkg::MODE_EQ, MINV, MAXV, MINV, MINV), 1, rs(0, 0, 0, 0, 0)};
      directed[16] = '{mk(cau_pkg::MODE_NE, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, 0)};
      directed[17] = '{mk(cau_pkg::MODE_NE, MAXV, 0, MINV, 0), 1, rs(0, 0, 1, 0, 0)};
      directed[18] = '{mk(MODE_UNUSED6, MAXV, MAXV, MAXV, MAXV), 1, rs(0, 0, 0, 0, 0)};
      directed[19] = '{mk(MODE_UNUSED7, MINV, MINV, MINV, MINV), 1, rs(0, 0, 0, 0, 0)};
   end

   function automatic logic signed [DW-1:0] rand_part();
      case ($urandom_range(0, 5))
         0: return MAXV;
         1: return MINV;
         2: return $signed(16'($urandom_range(0, 3))) - 16'sd1;
         3: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
         default: return $signed(16'($urandom));
      endcase
   endfunction

   function automatic operands_type rand_operands();
      operands_type o;
      o.mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
      o.ar = rand_part(); o.ai = rand_part();
      o.br = rand_part(); o.bi = rand_part();
      // make comparisons and zero divisors hit often
      if ($urandom_range(0, 3) == 0) begin
         o.br = o.ar; o.bi = o.ai;
      end
      if (o.mode == cau_pkg::MODE_DIV && $urandom_range(0, 7) == 0) begin
         o.br = '0; o.bi = '0;
      end
      return o;
   endfunction

   // gap of random length, mostly short, a few long
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // send one transaction, wait for its acceptance
   task automatic send_op(input operands_type op);
      req_ch.valid  <= 1'b1;
      req_ch.mode   <= op.mode;
      req_ch.a_real <= op.ar;
      req_ch.a_imag <= op.ai;
      req_ch.b_real <= op.br;
      req_ch.b_imag <= op.bi;
      do @(posedge clock); while (!req_ch.ready);
      n_sent++;
   endtask

   task automatic idle_req(input int n);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // sender
   initial begin
      operands_type op;
      req_ch.valid <= 1'b0;
      req_ch.mode <= '0;
      req_ch.a_real <= '0;
      req_ch.a_imag <= '0;
      req_ch.b_real <= '0;
      req_ch.b_imag <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < N_DIRECTED; i++) begin
         expected_q.push_back(directed[i].typed ? directed[i].res
                                                : complex_result(directed[i].op));
         send_op(directed[i].op);
         idle_req((i % 4 == 3) ? gap_len() : 0);
      end
      // pause until the pipeline drains
      idle_req(1);
      while (expected_q.size() != 0) @(posedge clock);
      for (int i = 0; i < N_RANDOM; i++) begin
         op = rand_operands();
         expected_q.push_back(complex_result(op));
         send_op(op);
         // hold-off starts where the sender runs without gaps
         if (i == 300) long_holdoff = 1'b1;
         if (i < 300 || i > 450) idle_req(gap_len());
      end
      req_ch.valid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver, with one long hold-off while the sender keeps going
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_holdoff) begin
            long_holdoff = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (120) @(posedge clock);
         end
         n = (n_results > 500 && n_results < 600) ? 0 : gap_len();
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      result_type e;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            idle_cycles <= 0;
            n_results++;
            if (expected_q.size() == 0) begin
               $error("result with nothing expected");
               errors++;
            end else begin
               e = expected_q.pop_front();
               n_sat += e.sat;
               n_dz += e.dz;
               if (rsp_ch.result_real !== e.rr) begin
                  $error("result_real: expected %0d, got %0d", e.rr, rsp_ch.result_real);
                  errors++;
               end
               if (rsp_ch.result_imag !== e.ri) begin
                  $error("result_imag: expected %0d, got %0d", e.ri, rsp_ch.result_imag);
                  errors++;
               end
               if (rsp_ch.compare_true !== e.cmp) begin
                  $error("compare_true: expected %0d, got %0d", e.cmp, rsp_ch.compare_true);
                  errors++;
               end
               if (rsp_ch.saturated !== e.sat) begin
                  $error("saturated: expected %0d, got %0d", e.sat, rsp_ch.saturated);
                  errors++;
               end
               if (rsp_ch.divide_by_zero !== e.dz) begin
                  $error("divide_by_zero: expected %0d, got %0d", e.dz,
                         rsp_ch.divide_by_zero);
                  errors++;
               end
            end
         end else if (req_ch.valid && req_ch.ready) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // end of run
   initial begin
      @(negedge reset);
      fork
         begin
            wait (sending_done && expected_q.size() == 0);
            repeat (LATENCY + 10) @(posedge clock);
         end
         wait (idle_cycles >= WATCHDOG_LIMIT);
      join_any
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_q.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         $display("run covered %0d transactions, %0d results, %0d saturated, %0d div by zero",
                  n_sent, n_results, n_sat, n_dz);
         $display("all modes incl. unused, directed extremes, long stall and drain pause");
         if (errors == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
         end else begin
            $display("DONE: errors detected");
         end
         $finish;
      end
   end

endmodule
